// ===== hdl/wscr_pkg.sv =====
`timescale 1ns / 1ps

package wscr_pkg;

  // Default grid dimensions
  localparam int GRID_X_DEF = 128;
  localparam int GRID_Y_DEF = 32;
  localparam int GRID_Z_DEF = 64;

  // Width used for window bound arithmetic (covers grid sizes up to 1024)
  localparam int BW = 12;

  // Counter and accumulator widths
  localparam int CNT_W = 17;
  localparam int SUM_W = 49;
  localparam int SQ_W  = 81;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAN = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_XY_REACH = 3'd3;
  localparam logic [2:0] REG_Z_REACH  = 3'd4;

  // Configuration reset values
  localparam logic [7:0] SIZE_X_RST   = 8'd90;
  localparam logic [5:0] SIZE_Y_RST   = 6'd20;
  localparam logic [6:0] SIZE_Z_RST   = 7'd61;
  localparam logic [4:0] XY_REACH_RST = 5'd10;
  localparam logic [6:0] Z_REACH_RST  = 7'd20;

  // Controller states
  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_RDWAIT = 12'b0000_0000_0100,
    S_SETUP  = 12'b0000_0000_1000,
    S_BASE   = 12'b0000_0001_0000,
    S_PASS1  = 12'b0000_0010_0000,
    S_MDIV   = 12'b0000_0100_0000,
    S_PASS2  = 12'b0000_1000_0000,
    S_VDIV   = 12'b0001_0000_0000,
    S_SQRT   = 12'b0010_0000_0000,
    S_PASS3  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== hdl/window_sigma_clip_replace.sv =====
`timescale 1ns / 1ps
// A write goes from IDLE straight to DONE, which registers its result; a read passes RDWAIT first.
// Clean: three memory walks at one cell per cycle, two 81-step divides and a 32-step root;
// with under two nonzero cells it ends after the first walk.
// One item at a time: the next beat is taken in the cycle after the result is parked.
// Reset: configuration returns to defaults, then a clearing pass writes zero to
// all GRID_X * GRID_Y * GRID_Z cells, one per cycle, with in_stall held high.

module window_sigma_clip_replace
  import wscr_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  x_pos,
  input  logic [4:0]  y_pos,
  input  logic [5:0]  z_pos,
  input  logic [31:0] cell_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic [31:0] deviation,
  output logic [16:0] nonzero_count,
  output logic [16:0] replaced_count,
  output logic        status
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam logic [AW-1:0] ROW_STRIDE   = AW'(GRID_X);
  localparam logic [AW-1:0] PLANE_STRIDE = AW'(GRID_X * GRID_Y);

  state_t state;

  // config registers
  logic [7:0] size_x;
  logic [5:0] size_y;
  logic [6:0] size_z;
  logic [4:0] xy_reach;
  logic [6:0] z_reach;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x   <= SIZE_X_RST;
      size_y   <= SIZE_Y_RST;
      size_z   <= SIZE_Z_RST;
      xy_reach <= XY_REACH_RST;
      z_reach  <= Z_REACH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_X:   size_x   <= cfg_data;
        REG_SIZE_Y:   size_y   <= cfg_data[5:0];
        REG_SIZE_Z:   size_z   <= cfg_data[6:0];
        REG_XY_REACH: xy_reach <= cfg_data[4:0];
        REG_Z_REACH:  z_reach  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input beat
  logic in_fire;
  logic in_grid;
  logic [AW-1:0] in_addr;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_grid  = ({5'b0, x_pos} < BW'(GRID_X)) && ({7'b0, y_pos} < BW'(GRID_Y))
                 && ({6'b0, z_pos} < BW'(GRID_Z));
  assign in_addr  = AW'(x_pos) + ROW_STRIDE * (AW'(y_pos) + AW'(GRID_Y) * AW'(z_pos));

  // latched window request
  logic [6:0] x_q;
  logic [4:0] y_q;
  logic [5:0] z_q;
  logic       rd_ok;

  // window bounds
  logic [BW-1:0] x0, x1, y0, y1, z0, z1, zlim;
  logic [XW-1:0] i0, ilast;
  logic [YW-1:0] j0, jlast;
  logic [ZW-1:0] k0, klast;
  logic          win_empty;

  always_comb begin
    x0 = ({5'b0, x_q} > BW'(xy_reach)) ? BW'(x_q) - BW'(xy_reach) : '0;
    y0 = ({7'b0, y_q} > BW'(xy_reach)) ? BW'(y_q) - BW'(xy_reach) : '0;
    z0 = BW'(z_q);
    x1 = (BW'(size_x) < BW'(GRID_X)) ? BW'(size_x) : BW'(GRID_X);
    if (BW'(x_q) + BW'(xy_reach) < x1) x1 = BW'(x_q) + BW'(xy_reach);
    y1 = (BW'(size_y) < BW'(GRID_Y)) ? BW'(size_y) : BW'(GRID_Y);
    if (BW'(y_q) + BW'(xy_reach) < y1) y1 = BW'(y_q) + BW'(xy_reach);
    zlim = (BW'(size_z) < BW'(GRID_Z)) ? BW'(size_z) : BW'(GRID_Z);
    z1 = zlim;
    if ((z_reach != '0) && (BW'(z_q) + BW'(z_reach) < zlim)) z1 = BW'(z_q) + BW'(z_reach);
  end

  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      win_empty <= (x0 >= x1) || (y0 >= y1) || (z0 >= z1);
      i0    <= x0[XW-1:0];
      j0    <= y0[YW-1:0];
      k0    <= z0[ZW-1:0];
      ilast <= XW'(x1 - 1'b1);
      jlast <= YW'(y1 - 1'b1);
      klast <= ZW'(z1 - 1'b1);
    end
  end

  // window walker
  logic [AW-1:0] base_addr;
  logic [AW-1:0] walk_addr, row_addr, plane_addr;
  logic [XW-1:0] wi;
  logic [YW-1:0] wj;
  logic [ZW-1:0] wk;
  logic          walk_active;
  logic          walk_load;
  logic          in_pass;

  assign in_pass = (state == S_PASS1) || (state == S_PASS2) || (state == S_PASS3);

  // first cell address, ready before the walker loads it
  always_ff @(posedge clk) begin
    if (state == S_SETUP)
      base_addr <= AW'(x0[XW-1:0])
                 + ROW_STRIDE * (AW'(y0[YW-1:0]) + AW'(GRID_Y) * AW'(z0[ZW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
    end else if (walk_load) begin
      walk_active <= !win_empty;
      wi          <= i0;
      wj          <= j0;
      wk          <= k0;
      walk_addr   <= base_addr;
      row_addr    <= base_addr;
      plane_addr  <= base_addr;
    end else if (in_pass && walk_active) begin
      if (wi == ilast) begin
        wi <= i0;
        if (wj == jlast) begin
          wj <= j0;
          if (wk == klast) begin
            walk_active <= 1'b0;
          end else begin
            wk         <= wk + 1'b1;
            plane_addr <= plane_addr + PLANE_STRIDE;
            row_addr   <= plane_addr + PLANE_STRIDE;
            walk_addr  <= plane_addr + PLANE_STRIDE;
          end
        end else begin
          wj        <= wj + 1'b1;
          row_addr  <= row_addr + ROW_STRIDE;
          walk_addr <= row_addr + ROW_STRIDE;
        end
      end else begin
        wi        <= wi + 1'b1;
        walk_addr <= walk_addr + 1'b1;
      end
    end
  end

  // cell memory: one write port, one registered read port
  logic [31:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [31:0]   rdata;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  assign mem_ra = (state == S_IDLE) ? in_addr : walk_addr;

  // read pipeline
  logic          rd_pend;
  logic [AW-1:0] addr_d;
  logic          sq_pend;
  logic [63:0]   sq_q;
  logic [31:0]   dabs;
  logic          nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      sq_pend <= 1'b0;
    end else begin
      rd_pend <= in_pass && walk_active;
      sq_pend <= (state == S_PASS2) && rd_pend && nz;
    end
  end

  // statistics
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  sq_acc;
  logic [31:0]      mean;
  logic [31:0]      dev;
  logic [CNT_W-1:0] replaced;
  logic [32:0]      lower, upper;
  logic             outlier;

  assign nz   = (rdata != '0);
  assign dabs = (rdata > mean) ? rdata - mean : mean - rdata;

  always_ff @(posedge clk) begin
    addr_d <= walk_addr;
    sq_q   <= 64'(dabs) * 64'(dabs);
  end

  always_comb begin
    lower   = (dev < mean) ? 33'(mean) - 33'(dev) : '0;
    upper   = 33'(mean) + 33'(dev);
    outlier = (33'(rdata) < lower) || (33'(rdata) > upper);
  end

  // write port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk_addr;
    mem_wd = '0;
    priority if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
    end else if (in_fire && (operation == OP_WRITE)) begin
      mem_we = in_grid;
      mem_wa = in_addr;
      mem_wd = cell_value;
    end else if ((state == S_PASS3) && rd_pend) begin
      mem_we = nz && outlier;
      mem_wa = addr_d;
      mem_wd = mean;
    end
  end

  // shared divider
  logic            div_start;
  logic [SQ_W-1:0] div_num;
  logic [CNT_W-1:0] div_den;
  logic            div_done;
  logic [SQ_W-1:0] div_quo;

  wscr_div #(
    .NW(SQ_W),
    .DW(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // square root unit, one result bit per step (two radicand bits)
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [63:0] sq_t, sq_v_nx, sq_res_nx;

  always_comb begin
    sq_t = sq_res + sq_bit;
    if (sq_v >= sq_t) begin
      sq_v_nx   = sq_v - sq_t;
      sq_res_nx = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_nx   = sq_v;
      sq_res_nx = sq_res >> 1;
    end
  end

  logic pass_end;
  assign pass_end = !walk_active && !rd_pend && !sq_pend;

  // result staging
  logic [31:0]      res_val, res_dev;
  logic [CNT_W-1:0] res_nz, res_rep;
  logic             res_stat;

  // main controller
  always_comb begin
    walk_load = 1'b0;
    div_start = 1'b0;
    div_num   = SQ_W'(sum + SUM_W'(cnt >> 1));
    div_den   = cnt;
    unique case (state)
      S_BASE: walk_load = 1'b1;
      S_PASS1: div_start = pass_end && (cnt >= CNT_W'(2));
      S_MDIV: walk_load = div_done;
      S_PASS2: begin
        div_start = pass_end;
        div_num   = sq_acc;
        div_den   = cnt - 1'b1;
      end
      S_SQRT: walk_load = sq_bit[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: load from DONE, clear once taken
      if ((state == S_DONE) && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            res_val  <= '0;
            res_dev  <= '0;
            res_nz   <= '0;
            res_rep  <= '0;
            res_stat <= 1'b0;
            x_q      <= x_pos;
            y_q      <= y_pos;
            z_q      <= z_pos;
            rd_ok    <= in_grid;
            priority if (operation == OP_READ) state <= S_RDWAIT;
            else if (operation == OP_CLEAN) state <= S_SETUP;
            else state <= S_DONE;
          end
        end
        S_RDWAIT: begin
          res_val <= rd_ok ? rdata : '0;
          state   <= S_DONE;
        end
        S_SETUP: state <= S_BASE;
        S_BASE: begin
          sum      <= '0;
          cnt      <= '0;
          sq_acc   <= '0;
          replaced <= '0;
          state    <= S_PASS1;
        end
        S_PASS1: begin
          if (rd_pend && nz) begin
            sum <= sum + SUM_W'(rdata);
            cnt <= cnt + 1'b1;
          end
          if (pass_end) begin
            res_nz <= cnt;
            if (cnt < CNT_W'(2)) begin
              res_stat <= 1'b1;
              state    <= S_DONE;
            end else begin
              state <= S_MDIV;
            end
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean  <= div_quo[31:0];
            state <= S_PASS2;
          end
        end
        S_PASS2: begin
          if (sq_pend) sq_acc <= sq_acc + SQ_W'(sq_q);
          if (pass_end) state <= S_VDIV;
        end
        S_VDIV: begin
          if (div_done) begin
            sq_v   <= (div_quo[SQ_W-1:64] != '0) ? '1 : div_quo[63:0];
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v   <= sq_v_nx;
          sq_res <= sq_res_nx;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            dev   <= sq_res_nx[31:0];
            state <= S_PASS3;
          end
        end
        S_PASS3: begin
          if (rd_pend && nz && outlier) replaced <= replaced + 1'b1;
          if (pass_end) begin
            res_val <= mean;
            res_dev <= dev;
            res_rep <= replaced;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            read_value     <= res_val;
            deviation      <= res_dev;
            nonzero_count  <= res_nz;
            replaced_count <= res_rep;
            status         <= res_stat;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_rep_le_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (replaced_count <= nonzero_count))
    else $error("replaced count above nonzero count");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (read_value == '0 && deviation == '0
                               && replaced_count == '0 && nonzero_count < 17'd2))
    else $error("short window result not cleared");

  a_no_write_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS1 || state == S_PASS2) |-> !mem_we)
    else $error("memory write during a read-only walk");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MDIV || state == S_VDIV))
    else $error("divider finished outside a divide state");

  a_walk_only_pass: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(in_pass))
    else $error("walk read issued outside a pass");

endmodule

// ===== hdl/wscr_div.sv =====
`timescale 1ns / 1ps

module wscr_div
  import wscr_pkg::*;
#(
  parameter int NW = SQ_W,
  parameter int DW = CNT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] d_q;
  logic [CW-1:0] left;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_nx;

  // One restoring step: shift in the next numerator bit, try the subtract
  always_comb begin
    rem_sh = {rem, q[NW-1]};
    ge     = (rem_sh >= {1'b0, d_q});
    rem_nx = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CW'(NW);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace numerator bits as they shift out
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d_q <= den;
    end else if (busy) begin
      q   <= {q[NW-2:0], ge};
      rem <= rem_nx[DW-1:0];
    end
  end

  assign quo = q;

endmodule
